// ===== sv/fusa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fusa_pkg;

    // Widths fixed by the word formats
    localparam int MAX_UNITS_DEF = 8;
    localparam int TIME_W        = 32;
    localparam int OCC_W         = 8;
    localparam int UCNT_W        = 4;
    localparam int OP_W          = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_GRANT    = 2'd0,
        OP_PEEK     = 2'd1,
        OP_OCCUPY   = 2'd2,
        OP_PEEK_ALT = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_COUNT = 2'd0,
        CFG_OCCUPANCY  = 2'd1
    } t_cfg_reg;

    // Pool modes, chosen by unit count and occupancy
    typedef enum logic [2:0] {
        MODE_UNLIM = 3'd0,
        MODE_FULL1 = 3'd1,
        MODE_FULLN = 3'd2,
        MODE_OCC1  = 3'd3,
        MODE_OCCN  = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_DECODE   = 4'd1,
        ST_SCAN_RD  = 4'd2,
        ST_SCAN_EV  = 4'd3,
        ST_DIV_RD   = 4'd4,
        ST_DIV_GO   = 4'd5,
        ST_DIV_WAIT = 4'd6,
        ST_DIV_WR   = 4'd7,
        ST_FIN4     = 4'd8,
        ST_OUT      = 4'd9
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the input word
        logic init;      // clear scan trackers and unit index
        logic simple;    // update in the decode state for the scalar modes
        logic scan_ev;   // evaluate one timer read
        logic div_go;    // start the remainder unit
        logic div_wr;    // write back an advanced time
        logic fin4;      // final timer update of the multi-unit path
        logic out_load;  // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_mode mode;
        t_op   op;
        logic  occ_active;  // now < until_time
        logic  idx_last;    // unit index at last unit of the pool
        logic  div_done;
        logic  out_free;
    } t_stat;

    // Saturating time add
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [OCC_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - OCC_W){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/fusa_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel
interface fusa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] now;
    logic [31:0] until_time;
    logic        own_occupancy;
    logic [7:0]  request_occupancy;

    modport source (output valid, op, now, until_time, own_occupancy, request_occupancy,
                    input ready);
    modport sink   (input valid, op, now, until_time, own_occupancy, request_occupancy,
                    output ready);
endinterface

// Result channel
interface fusa_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] slot;

    modport source (output valid, slot, input ready);
    modport sink   (input valid, slot, output ready);
endinterface

// Configuration write channel
interface fusa_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/fusa_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial restoring remainder: 32-bit dividend by 8-bit divisor,
// one quotient bit per cycle.
module fusa_rem (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [fusa_pkg::TIME_W-1:0] i_dividend,
    input  wire logic [fusa_pkg::OCC_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [fusa_pkg::OCC_W-1:0]       o_rem
);
    import fusa_pkg::*;

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_dvd;
    logic [OCC_W-1:0]  r_rem;
    logic [OCC_W:0]    w_trial;
    logic [OCC_W:0]    w_diff;

    // Shift in the next dividend bit and try to subtract
    assign w_trial = {r_rem, r_dvd[TIME_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(TIME_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= (w_trial >= {1'b0, i_divisor}) ? w_diff[OCC_W-1:0]
                                                    : w_trial[OCC_W-1:0];
        end
    end

    assign o_done = !r_busy;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== sv/fusa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Allocator datapath: config registers, scalar slot state, busy-until timer
// memory, scan trackers, remainder unit and output register.
module fusa_dp #(
    parameter int MAX_UNITS = fusa_pkg::MAX_UNITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fusa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fusa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [fusa_pkg::OP_W-1:0]       i_op,
    input  wire logic [fusa_pkg::TIME_W-1:0]     i_now,
    input  wire logic [fusa_pkg::TIME_W-1:0]     i_until_time,
    input  wire logic                            i_own_occupancy,
    input  wire logic [fusa_pkg::OCC_W-1:0]      i_request_occupancy,
    input  wire fusa_pkg::t_cmd                  i_cmd,
    output fusa_pkg::t_stat                      o_stat,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [fusa_pkg::TIME_W-1:0]          o_out_slot
);
    import fusa_pkg::*;

    localparam int IW   = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CW   = (IW > UCNT_W) ? IW : UCNT_W;
    localparam int UCAP = (MAX_UNITS < 15) ? MAX_UNITS : 15;

    function automatic logic [UCNT_W-1:0] cap_units(input logic [UCNT_W-1:0] u);
        return (u > UCNT_W'(UCAP)) ? UCNT_W'(UCAP) : u;
    endfunction

    // Architectural state
    logic [UCNT_W-1:0] r_ucount;
    logic [OCC_W-1:0]  r_occ;
    logic [TIME_W-1:0] r_last;
    logic [UCNT_W-1:0] r_free;
    logic [TIME_W-1:0] r_mem [MAX_UNITS];
    logic [MAX_UNITS-1:0] r_bv;
    logic [TIME_W-1:0] r_q;
    logic              r_qv;

    // Current word and work registers
    t_op               r_op;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_until;
    logic [OCC_W-1:0]  r_gocc;
    logic [IW-1:0]     r_idx;
    logic              r_found;
    logic [IW-1:0]     r_fidx;
    logic [TIME_W-1:0] r_minv;
    logic [IW-1:0]     r_midx;
    logic [TIME_W-1:0] r_base;
    logic [TIME_W-1:0] r_res;
    logic              r_ovalid;
    logic [TIME_W-1:0] r_oslot;

    logic [UCNT_W-1:0] w_n;
    t_mode             w_mode;
    logic [TIME_W-1:0] w_rd;
    logic [TIME_W-1:0] w_src;
    logic [TIME_W-1:0] w_base;
    logic [TIME_W-1:0] w_dvd;
    logic              w_div_done;
    logic [OCC_W-1:0]  w_rem;
    logic [TIME_W-1:0] w_adv;
    logic [TIME_W-1:0] w_g1;
    logic [TIME_W-1:0] w_fn_last;
    logic [UCNT_W-1:0] w_fn_free;
    logic [TIME_W-1:0] w_s_res;
    logic              w_s_wr;
    logic [TIME_W-1:0] n_last;
    logic [UCNT_W-1:0] n_free;
    logic              w_we;
    logic [IW-1:0]     w_wa;
    logic [TIME_W-1:0] w_wd;
    logic [TIME_W-1:0] w_f_res;
    logic              w_cfg_hit;

    // Mode decode
    assign w_n = cap_units(r_ucount);
    always_comb begin
        if (w_n == '0 || r_occ == '0) begin
            w_mode = MODE_UNLIM;
        end else if (r_occ == OCC_W'(1)) begin
            w_mode = (w_n == UCNT_W'(1)) ? MODE_FULL1 : MODE_FULLN;
        end else begin
            w_mode = (w_n == UCNT_W'(1)) ? MODE_OCC1 : MODE_OCCN;
        end
    end

    // Timer read data; never-written timers read as zero
    assign w_rd = r_qv ? r_q : '0;

    // Start point of an occupy advance and distance to the target
    assign w_src  = (w_mode == MODE_OCCN) ? w_rd : r_last;
    assign w_base = (w_src < r_now) ? r_now : w_src;
    assign w_dvd  = (w_base < r_until) ? (r_until - w_base) : '0;

    fusa_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (w_dvd),
        .i_divisor  (r_occ),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // First base + k*occ at or past until_time, from the remainder
    always_comb begin
        if (r_base >= r_until) begin
            w_adv = r_base;
        end else if (w_rem == '0) begin
            w_adv = r_until;
        end else begin
            w_adv = sat_add(r_until, r_occ - w_rem);
        end
    end

    // Fully pipelined N-unit grant
    assign w_g1 = (r_last < r_now) ? r_now : r_last;
    always_comb begin
        if (r_last < r_now) begin
            w_fn_last = r_now;
            w_fn_free = w_n - UCNT_W'(1);
        end else if (r_free != '0) begin
            w_fn_last = r_last;
            w_fn_free = r_free - UCNT_W'(1);
        end else begin
            w_fn_last = sat_add(r_last, OCC_W'(1));
            w_fn_free = w_n - UCNT_W'(1);
        end
    end

    // Scalar modes, done in the decode state
    always_comb begin
        w_s_res = r_now;
        w_s_wr  = 1'b0;
        n_last  = r_last;
        n_free  = r_free;
        case (w_mode)
            MODE_FULL1, MODE_OCC1: begin
                if (r_op == OP_GRANT) begin
                    w_s_res = w_g1;
                    w_s_wr  = 1'b1;
                    n_last  = sat_add(w_g1, r_occ);
                end else if (r_op != OP_OCCUPY) begin
                    w_s_res = w_g1;
                end
            end
            MODE_FULLN: begin
                if (r_op == OP_GRANT) begin
                    w_s_res = w_fn_last;
                    w_s_wr  = 1'b1;
                    n_last  = w_fn_last;
                    n_free  = w_fn_free;
                end else if (r_op == OP_OCCUPY) begin
                    if (r_now < r_until) begin
                        w_s_wr = 1'b1;
                        if (w_fn_last >= r_until) begin
                            w_s_res = w_fn_last;
                            n_last  = w_fn_last;
                            n_free  = w_fn_free;
                        end else begin
                            w_s_res = r_until;
                            n_last  = r_until;
                            n_free  = w_n - UCNT_W'(1);
                        end
                    end
                end else begin
                    w_s_res = (r_last < r_now) ? r_now
                            : sat_add(r_last, {{(OCC_W-1){1'b0}}, r_free == '0});
                end
            end
            default: begin
                w_s_res = r_now;
            end
        endcase
    end

    // Final step of the multi-unit path
    always_comb begin
        w_f_res = r_minv;
        w_we    = 1'b0;
        w_wa    = r_idx;
        w_wd    = w_adv;
        if (i_cmd.div_wr && w_mode == MODE_OCCN) begin
            w_we = 1'b1;
        end else if (i_cmd.fin4) begin
            case (r_op)
                OP_OCCUPY: begin
                    w_we = 1'b1;
                    w_wa = r_midx;
                    w_wd = sat_add(r_minv, r_occ);
                end
                OP_GRANT: begin
                    w_we = 1'b1;
                    if (r_found) begin
                        w_wa    = r_fidx;
                        w_wd    = sat_add(r_now, r_gocc);
                        w_f_res = r_now;
                    end else begin
                        w_wa = r_midx;
                        w_wd = sat_add(r_minv, r_gocc);
                    end
                end
                default: begin
                    w_f_res = (r_minv < r_now) ? r_now : r_minv;
                end
            endcase
        end
    end

    assign w_cfg_hit = i_cfg_we && (i_cfg_index == CFG_UNIT_COUNT ||
                                    i_cfg_index == CFG_OCCUPANCY);

    // Timer memory, registered read at the unit index
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_q <= r_mem[r_idx];
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ucount <= UCNT_W'(1);
            r_occ    <= OCC_W'(1);
            r_last   <= '0;
            r_free   <= cap_units(UCNT_W'(1));
            r_bv     <= '0;
            r_qv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_qv <= r_bv[r_idx];
            if (w_we) begin
                r_bv[w_wa] <= 1'b1;
            end
            if ((i_cmd.simple && w_s_wr) ||
                (i_cmd.div_wr && w_mode != MODE_OCCN)) begin
                r_last <= i_cmd.simple ? n_last : sat_add(w_adv, r_occ);
            end
            if (i_cmd.simple && w_s_wr) begin
                r_free <= n_free;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            // A register write rebuilds the pool
            if (w_cfg_hit) begin
                r_last <= '0;
                r_bv   <= '0;
                if (i_cfg_index == CFG_UNIT_COUNT) begin
                    r_ucount <= i_cfg_data[UCNT_W-1:0];
                    r_free   <= cap_units(i_cfg_data[UCNT_W-1:0]);
                end else begin
                    r_occ  <= i_cfg_data[OCC_W-1:0];
                    r_free <= cap_units(r_ucount);
                end
            end
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_op);
            r_now   <= i_now;
            r_until <= i_until_time;
            r_gocc  <= i_own_occupancy ? i_request_occupancy : r_occ;
        end
        if (i_cmd.init) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.simple) begin
            r_res <= w_s_res;
        end
        if (i_cmd.div_go) begin
            r_base <= w_base;
        end
        // Timer scan: first expired unit and lowest-index minimum
        if (i_cmd.scan_ev) begin
            if (!r_found && w_rd < r_now) begin
                r_found <= 1'b1;
                r_fidx  <= r_idx;
            end
            if (r_idx == '0 || w_rd < r_minv) begin
                r_minv <= w_rd;
                r_midx <= r_idx;
            end
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.div_wr) begin
            if (w_mode == MODE_OCCN) begin
                if (r_idx == '0 || w_adv < r_minv) begin
                    r_minv <= w_adv;
                    r_midx <= r_idx;
                end
                r_idx <= r_idx + IW'(1);
            end else begin
                r_res <= w_adv;
            end
        end
        if (i_cmd.fin4) begin
            r_res <= w_f_res;
        end
        if (i_cmd.out_load) begin
            r_oslot <= r_res;
        end
    end

    assign o_stat.mode       = w_mode;
    assign o_stat.op         = r_op;
    assign o_stat.occ_active = (r_now < r_until);
    assign o_stat.idx_last   = (CW'(r_idx) == CW'(w_n - UCNT_W'(1)));
    assign o_stat.div_done   = w_div_done;
    assign o_stat.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_slot  = r_oslot;

endmodule

`default_nettype wire

// ===== sv/fusa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Allocator sequencer: one request word at a time
module fusa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire fusa_pkg::t_stat i_stat,
    output fusa_pkg::t_cmd       o_cmd
);
    import fusa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_scan;
    logic   w_multi_occ;
    logic   w_single_occ;
    logic   w_simple;

    // Path selection after decode
    assign w_scan       = (i_stat.mode == MODE_OCCN) && (i_stat.op != OP_OCCUPY);
    assign w_multi_occ  = (i_stat.mode == MODE_OCCN) && (i_stat.op == OP_OCCUPY) &&
                          i_stat.occ_active;
    assign w_single_occ = (i_stat.mode == MODE_FULL1 || i_stat.mode == MODE_OCC1) &&
                          (i_stat.op == OP_OCCUPY) && i_stat.occ_active;
    assign w_simple     = !w_scan && !w_multi_occ && !w_single_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (w_scan) begin
                    n_state = ST_SCAN_RD;
                end else if (w_multi_occ) begin
                    n_state = ST_DIV_RD;
                end else if (w_single_occ) begin
                    n_state = ST_DIV_GO;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_SCAN_RD:  n_state = ST_SCAN_EV;
            ST_SCAN_EV:  n_state = i_stat.idx_last ? ST_FIN4 : ST_SCAN_RD;
            ST_DIV_RD:   n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (i_stat.div_done) n_state = ST_DIV_WR;
            end
            ST_DIV_WR: begin
                if (i_stat.mode != MODE_OCCN) begin
                    n_state = ST_OUT;
                end else if (i_stat.idx_last) begin
                    n_state = ST_FIN4;
                end else begin
                    n_state = ST_DIV_RD;
                end
            end
            ST_FIN4:     n_state = ST_OUT;
            ST_OUT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: begin
                o_cmd.init   = 1'b1;
                o_cmd.simple = w_simple;
            end
            ST_SCAN_EV: o_cmd.scan_ev  = 1'b1;
            ST_DIV_GO:  o_cmd.div_go   = 1'b1;
            ST_DIV_WR:  o_cmd.div_wr   = 1'b1;
            ST_FIN4:    o_cmd.fin4     = 1'b1;
            ST_OUT:     o_cmd.out_load = i_stat.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/functional_unit_slot_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Payload
// i_in     in   valid/ready    op, now, until_time, own_occupancy, request_occupancy
// o_out    out  valid/ready    slot
// i_cfg    in   valid/ready    index (0 unit_count, 1 occupancy), data
//
// One request word at a time. Unlimited, single-unit and fully pipelined N-unit
// requests pass through accept, decode and output, except an active occupy-until
// with one unit. Multi-unit grant/peek scans the timer memory, a read and an
// evaluate per unit. An active occupy-until with one unit or with unit timers
// runs the bit-serial remainder unit once per timer. Synchronous reset; timers
// carry valid bits, so there is no clearing pass. A finished result waits in the
// output register while the next request word is accepted and worked on; a full
// output register holds the sequencer in its output state.
module functional_unit_slot_allocator_core #(
    parameter int MAX_UNITS = fusa_pkg::MAX_UNITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fusa_in_if.sink     i_in,
    fusa_out_if.source  o_out,
    fusa_cfg_if.sink    i_cfg
);
    import fusa_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    fusa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fusa_dp #(
        .MAX_UNITS (MAX_UNITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .i_op                (i_in.op),
        .i_now               (i_in.now),
        .i_until_time        (i_in.until_time),
        .i_own_occupancy     (i_in.own_occupancy),
        .i_request_occupancy (i_in.request_occupancy),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_out_slot          (o_out.slot)
    );

    // One word in flight: no new request right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while previous word still in work");

    // Output register only reloaded when empty or being drained
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten");

    // Remainder unit started only when idle
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_go |-> w_stat.div_done)
        else $error("remainder unit restarted while busy");

    // Remainder unit is busy the cycle after a start
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_go |=> !w_stat.div_done)
        else $error("remainder unit did not start");

endmodule

`default_nettype wire
